>>> rtl/bsfp_pkg.sv
package bsfp_pkg;

  localparam int FIELD_W   = 32;
  localparam int COST_W    = 64;
  localparam int FEE_W     = 64;
  localparam int SCALE_W   = 20;
  localparam logic [SCALE_W-1:0] CENTIBPS_SCALE = 20'd1000000;
  localparam int NPROD_W   = FIELD_W + SCALE_W;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;
  localparam int DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd64;
  localparam int PADDR_W   = 3;
  localparam logic [0:0] REG_FEE_FRACTION = 1'b0;

  typedef struct packed {
    logic [FIELD_W-1:0] level_price;
    logic [FIELD_W-1:0] level_size;
    logic               first_level;
    logic               last_level;
    logic               book_empty;
    logic [FIELD_W-1:0] order_quantity;
    logic [FIELD_W-1:0] mid_ticks;
    logic [FIELD_W-1:0] spread_ticks;
    logic               is_buy;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] avg_price;
    logic [FIELD_W-1:0] impact_ticks;
    logic [FIELD_W-1:0] slippage_centibps;
    logic [FEE_W-1:0]   fee_amount;
  } out_item_t;

  // one finished order waiting for pricing
  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [FIELD_W-1:0] divisor;
    logic               use_div;
    logic [FIELD_W-1:0] best;
    logic [FIELD_W-1:0] mid;
    logic [FIELD_W-1:0] qty;
  } job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FDIV  = 9'b000000010,
    S_PREP  = 9'b000000100,
    S_SLIP  = 9'b000001000,
    S_SWAIT = 9'b000010000,
    S_FEE1  = 9'b000100000,
    S_FEE2  = 9'b001000000,
    S_FEE3  = 9'b010000000,
    S_OUT   = 9'b100000000
  } back_state_t;

endpackage

>>> rtl/bsfp_div.sv
module bsfp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bsfp_pkg::COST_W-1:0]    dividend,
  input  logic [bsfp_pkg::FIELD_W-1:0]   divisor,
  output logic                           done,
  output logic [bsfp_pkg::COST_W-1:0]    quotient
);

  logic [bsfp_pkg::DIV_CNT_W-1:0] cnt;
  logic [bsfp_pkg::FIELD_W-1:0]   rem;
  logic [bsfp_pkg::FIELD_W-1:0]   dvs;
  logic [bsfp_pkg::FIELD_W:0]     shifted;
  logic                           fits;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem, quotient[bsfp_pkg::COST_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= bsfp_pkg::DIV_STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == bsfp_pkg::DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (cnt != '0) begin
      if (fits) begin
        rem      <= bsfp_pkg::FIELD_W'(shifted - {1'b0, dvs});
        quotient <= {quotient[bsfp_pkg::COST_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[bsfp_pkg::FIELD_W-1:0];
        quotient <= {quotient[bsfp_pkg::COST_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/bsfp_front.sv
module bsfp_front #(
  parameter int PRICE_BITS = 32,
  parameter int QTY_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bsfp_pkg::in_item_t item,
  input  bsfp_pkg::q_stat_t  q_stat,
  output logic               busy,
  output logic               push,
  output bsfp_pkg::job_t     job
);

  localparam int PW    = PRICE_BITS;
  localparam int QW    = QTY_BITS;
  localparam int PRODW = PRICE_BITS + QTY_BITS;

  logic [PW-1:0] price, mid, spread, half_dn, half_up, emp_fill;
  logic [PW:0]   buy_sum;
  logic [QW-1:0] size, qty, rem_eff, take, filled;
  logic          accept, eff_open;

  logic [QW-1:0]    remaining;
  logic [PW-1:0]    best;
  logic             open;
  logic [bsfp_pkg::COST_W-1:0] cost, cost_next;

  logic             s_vld, s_first, s_last, s_empty;
  logic [PRODW-1:0] s_prod;
  logic [QW-1:0]    s_qty;
  logic [PW-1:0]    s_mid, s_fill;

  assign price  = item.level_price[PW-1:0];
  assign mid    = item.mid_ticks[PW-1:0];
  assign spread = item.spread_ticks[PW-1:0];
  assign size   = item.level_size[QW-1:0];
  assign qty    = item.order_quantity[QW-1:0];

  assign busy   = s_vld || q_stat.full;
  assign accept = start && !busy;

  assign eff_open = item.first_level || open;
  assign rem_eff  = item.first_level ? qty : remaining;
  assign take     = (rem_eff < size) ? rem_eff : size;

  // spread model for an empty book
  assign half_dn  = spread >> 1;
  assign half_up  = half_dn + PW'(spread[0]);
  assign buy_sum  = {1'b0, mid} + {1'b0, half_dn};
  assign emp_fill = item.is_buy ? (buy_sum[PW] ? {PW{1'b1}} : buy_sum[PW-1:0])
                                : ((mid >= half_up) ? (mid - half_up) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      best      <= '0;
      open      <= 1'b0;
      cost      <= '0;
      s_vld     <= 1'b0;
    end else begin
      s_vld <= 1'b0;
      if (s_vld && !s_empty) begin
        cost <= cost_next;
      end
      if (accept) begin
        if (item.book_empty) begin
          open  <= 1'b0;
          s_vld <= 1'b1;
        end else if (eff_open) begin
          if (item.first_level) begin
            best <= price;
          end
          remaining <= rem_eff - take;
          open      <= !item.last_level;
          s_vld     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_first <= item.first_level;
      s_last  <= item.last_level;
      s_empty <= item.book_empty;
      s_prod  <= take * price;
      s_qty   <= qty;
      s_mid   <= mid;
      s_fill  <= emp_fill;
    end
  end

  assign cost_next = (s_first ? '0 : cost) + bsfp_pkg::COST_W'(s_prod);
  assign filled    = (s_qty > remaining) ? (s_qty - remaining) : '0;

  assign push        = s_vld && (s_empty || s_last);
  assign job.cost    = s_empty ? '0 : cost_next;
  assign job.divisor = bsfp_pkg::FIELD_W'(filled);
  assign job.use_div = !s_empty && (filled != '0);
  assign job.best    = bsfp_pkg::FIELD_W'(s_empty ? s_fill : best);
  assign job.mid     = bsfp_pkg::FIELD_W'(s_mid);
  assign job.qty     = bsfp_pkg::FIELD_W'(s_qty);

endmodule

>>> rtl/bsfp_queue.sv
module bsfp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bsfp_pkg::job_t    job_in,
  input  logic              pop,
  output bsfp_pkg::q_stat_t q_stat,
  output bsfp_pkg::job_t    head
);

  bsfp_pkg::job_t mem [bsfp_pkg::Q_DEPTH];
  logic [bsfp_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [bsfp_pkg::Q_CNT_W-1:0] count;

  assign q_stat.full     = count == bsfp_pkg::Q_CNT_W'(bsfp_pkg::Q_DEPTH);
  assign q_stat.nonempty = count != '0;
  assign head            = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= job_in;
    end
  end

endmodule

>>> rtl/bsfp_back.sv
module bsfp_back #(
  parameter int PRICE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bsfp_pkg::q_stat_t             q_stat,
  input  bsfp_pkg::job_t                head,
  input  logic [bsfp_pkg::FIELD_W-1:0]  fee_fraction,
  output logic                          pop,
  output logic                          done,
  output bsfp_pkg::out_item_t           result
);

  localparam int FW = bsfp_pkg::FIELD_W;

  bsfp_pkg::back_state_t state, state_next;
  bsfp_pkg::job_t        j;

  logic [FW-1:0]                   fill, slip, mid_gap, impact, q_fill, q_slip;
  logic [bsfp_pkg::NPROD_W-1:0]    nprod;
  logic [bsfp_pkg::FEE_W-1:0]      p, fa, fb;
  logic                            div_start, div_done;
  logic [bsfp_pkg::COST_W-1:0]     div_a, quo;
  logic [FW-1:0]                   div_b;

  assign pop = (state == bsfp_pkg::S_IDLE) && q_stat.nonempty;

  assign div_start = (pop && head.use_div) ||
                     ((state == bsfp_pkg::S_SLIP) && (j.mid != '0));
  assign div_a = (state == bsfp_pkg::S_IDLE) ? head.cost : bsfp_pkg::COST_W'(nprod);
  assign div_b = (state == bsfp_pkg::S_IDLE) ? head.divisor : j.mid;

  bsfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  assign q_fill  = (|quo[bsfp_pkg::COST_W-1:PRICE_BITS]) ? FW'({PRICE_BITS{1'b1}})
                                                          : FW'(quo[PRICE_BITS-1:0]);
  assign q_slip  = (|quo[bsfp_pkg::COST_W-1:FW]) ? '1 : quo[FW-1:0];
  assign mid_gap = (fill >= j.mid) ? (fill - j.mid) : (j.mid - fill);
  assign impact  = (fill >= j.best) ? (fill - j.best) : (j.best - fill);

  always_comb begin
    state_next = state;
    case (state)
      bsfp_pkg::S_IDLE:  if (q_stat.nonempty) begin
        state_next = head.use_div ? bsfp_pkg::S_FDIV : bsfp_pkg::S_PREP;
      end
      bsfp_pkg::S_FDIV:  if (div_done) begin
        state_next = bsfp_pkg::S_PREP;
      end
      bsfp_pkg::S_PREP:  state_next = bsfp_pkg::S_SLIP;
      bsfp_pkg::S_SLIP:  state_next = (j.mid != '0) ? bsfp_pkg::S_SWAIT : bsfp_pkg::S_FEE1;
      bsfp_pkg::S_SWAIT: if (div_done) begin
        state_next = bsfp_pkg::S_FEE1;
      end
      bsfp_pkg::S_FEE1:  state_next = bsfp_pkg::S_FEE2;
      bsfp_pkg::S_FEE2:  state_next = bsfp_pkg::S_FEE3;
      bsfp_pkg::S_FEE3:  state_next = bsfp_pkg::S_OUT;
      bsfp_pkg::S_OUT:   state_next = bsfp_pkg::S_IDLE;
      default:           state_next = bsfp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsfp_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == bsfp_pkg::S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bsfp_pkg::S_IDLE: begin
        j    <= head;
        fill <= head.best;
      end
      bsfp_pkg::S_FDIV: if (div_done) begin
        fill <= q_fill;
      end
      bsfp_pkg::S_PREP: nprod <= mid_gap * bsfp_pkg::CENTIBPS_SCALE;
      bsfp_pkg::S_SLIP: slip <= '0;
      bsfp_pkg::S_SWAIT: if (div_done) begin
        slip <= q_slip;
      end
      bsfp_pkg::S_FEE1: p  <= j.qty * fill;
      bsfp_pkg::S_FEE2: fa <= p[bsfp_pkg::FEE_W-1:FW] * fee_fraction;
      bsfp_pkg::S_FEE3: fb <= p[FW-1:0] * fee_fraction;
      bsfp_pkg::S_OUT: begin
        result.avg_price         <= fill;
        result.impact_ticks      <= impact;
        result.slippage_centibps <= slip;
        result.fee_amount        <= fa + (fb >> FW);
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/book_sweep_fill_pricer.sv
// level items: an accepted level of an open order is held in the front's registered
// stage, and busy stays high while that stage holds it or while the job queue is full
// order result: done strobes after the back runs the fill-price division (64-step,
// when any qty filled), the slippage division (when mid is nonzero) and fee steps
// the back prices one order at a time; two finished orders may queue
// synchronous reset clears control state and fee_fraction, no clearing pass
module book_sweep_fill_pricer #(
  parameter int PRICE_BITS = 32,
  parameter int QTY_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  bsfp_pkg::in_item_t             item,
  output logic                           done,
  output bsfp_pkg::out_item_t            result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsfp_pkg::PADDR_W-1:0]   paddr,
  input  logic [bsfp_pkg::FIELD_W-1:0]   pwdata,
  output logic [bsfp_pkg::FIELD_W-1:0]   prdata,
  output logic                           pready
);

  logic [bsfp_pkg::FIELD_W-1:0] fee_fraction;
  logic                         push, pop;
  bsfp_pkg::job_t               job, head;
  bsfp_pkg::q_stat_t            q_stat;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[bsfp_pkg::PADDR_W-1] == bsfp_pkg::REG_FEE_FRACTION;
  assign prdata  = reg_sel ? fee_fraction : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fee_fraction <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      fee_fraction <= pwdata;
    end
  end

  bsfp_front #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .q_stat (q_stat),
    .busy   (busy),
    .push   (push),
    .job    (job)
  );

  bsfp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  bsfp_back #(.PRICE_BITS(PRICE_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .head         (head),
    .fee_fraction (fee_fraction),
    .pop          (pop),
    .done         (done),
    .result       (result)
  );

  // a result transfer lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held");

  // an accepted empty-book item always occupies the front in the next cycle
  a_empty_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.book_empty) |=> busy)
    else $error("empty-book item not taken");

  // no push into a full queue unless a pop frees a slot in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!q_stat.full || pop))
    else $error("job queue overflow");

endmodule
